// ===== hdl/trm_pkg.sv =====
// Shared types and constants for the traffic rate meter.
package trm_pkg;

   // Fixed field widths of the transaction payloads
   localparam int CMD_W     = 3;
   localparam int NOW_W     = 32;
   localparam int COUNT_W   = 48;
   localparam int STATUS_W  = 3;
   localparam int ELAPSED_W = 31;
   localparam int RATE_W    = 61;

   // Channel and lane organization
   localparam int CHANNEL_COUNT = 3;
   localparam int CH_W          = 2;
   localparam int LANES         = 4;
   localparam int LANE_W        = 2;

   localparam logic [CH_W-1:0]   CH_USER       = 2'd2;
   localparam logic [LANE_W-1:0] LANE_PACKETS  = 2'd2;
   localparam logic [LANE_W-1:0] LAST_LANE_NET = 2'd2;
   localparam logic [LANE_W-1:0] LAST_LANE_USR = 2'd3;

   // Rate scaling: bits per second from bytes per ms, units per second from units per ms
   localparam logic [63:0] RATE_MAX   = (64'd1 << RATE_W) - 64'd1;
   localparam logic [63:0] BIT_LIMIT  = RATE_MAX / 64'd8000;
   localparam logic [63:0] UNIT_LIMIT = RATE_MAX / 64'd1000;

   // Command codes; codes above CMD_CLEAR_RATES are invalid
   localparam logic [CMD_W-1:0] CMD_SAMPLE_RX   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SAMPLE_TX   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SAMPLE_USER = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR_ALL   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR_RATES = 3'd4;

   typedef enum logic [STATUS_W-1:0] {
      ST_UPDATED  = 3'd0,
      ST_BASELINE = 3'd1,
      ST_STALE    = 3'd2,
      ST_CLEARED  = 3'd3,
      ST_INVALID  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_DIV_LOAD,
      FSM_DIV_WAIT,
      FSM_SCALE,
      FSM_FINISH,
      FSM_RESP
   } state_type;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [NOW_W-1:0]   now_ms;
      logic [COUNT_W-1:0] count_a;
      logic [COUNT_W-1:0] count_b;
      logic [COUNT_W-1:0] count_c;
      logic [COUNT_W-1:0] count_d;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [ELAPSED_W-1:0] elapsed_ms;
      logic [RATE_W-1:0]    rate_a;
      logic [RATE_W-1:0]    rate_b;
      logic [RATE_W-1:0]    rate_c;
      logic [RATE_W-1:0]    rate_d;
   } rsp_type;

endpackage

// ===== hdl/trm_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
module trm_divider import trm_pkg::*; #(
   parameter int DIVIDEND_BITS = 48,
   parameter int DIVISOR_BITS  = 31
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic                     done,
   output logic [DIVIDEND_BITS-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_BITS + 1);

   logic                     running_ff;
   logic                     done_ff;
   logic [CNT_W-1:0]         count_ff;
   logic [DIVISOR_BITS-1:0]  rem_ff;
   logic [DIVISOR_BITS-1:0]  divisor_ff;
   logic [DIVIDEND_BITS-1:0] quo_ff;

   logic [DIVISOR_BITS:0]    trial;
   logic [DIVISOR_BITS:0]    diff;
   logic                     fits;

   // Trial subtract of the shifted partial remainder
   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
      diff  = trial - {1'b0, divisor_ff};
      fits  = (trial >= {1'b0, divisor_ff});
   end

   // Control: bit counter and done pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         count_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            running_ff <= 1'b1;
            count_ff   <= CNT_W'(DIVIDEND_BITS);
         end else if (running_ff) begin
            count_ff <= count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1)) begin
               running_ff <= 1'b0;
               done_ff    <= 1'b1;
            end
         end
      end
   end

   // Datapath: dividend shifts out the top while quotient bits shift in
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff     <= '0;
         divisor_ff <= divisor;
         quo_ff     <= dividend;
      end else if (running_ff) begin
         rem_ff <= fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
         quo_ff <= {quo_ff[DIVIDEND_BITS-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hdl/traffic_rate_meter.sv =====
// Traffic rate meter top level: command sequencer, channel state and response register.
//
//   channel | direction | payload  | handshake
//   req_    | in        | req_type | req_valid / req_stall
//   rsp_    | out       | rsp_type | rsp_valid / rsp_stall
//
// One transaction at a time. Clear and invalid commands, baseline captures and
// samples with no time advance go from EXEC through FINISH to RESP, where the
// response is valid. A rate update runs the shared serial divider once per counter
// (three counters for receive/transmit, four for user), each counter passing through
// DIV_LOAD, DIV_WAIT and SCALE before FINISH and RESP. Reset is synchronous and
// clears all channel state.
// A stalled response holds; req_stall stays high until it is taken.
module traffic_rate_meter import trm_pkg::*; #(
   parameter int COUNTER_BITS = 48,
   parameter int TIME_BITS    = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   state_type state_ff, state_in;

   // Captured transaction
   logic [CMD_W-1:0]        cmd_ff;
   logic [TIME_BITS-1:0]    now_ff;
   logic [COUNTER_BITS-1:0] cnt_ff [LANES];
   logic [CH_W-1:0]         ch_ff;
   logic [LANE_W-1:0]       last_lane_ff;
   logic [LANE_W-1:0]       lane_ff;
   logic [TIME_BITS-2:0]    elapsed_ff;
   status_type              status_ff;
   rsp_type                 rsp_ff;

   // Channel state
   logic                    baseline_ff [CHANNEL_COUNT];
   logic [TIME_BITS-1:0]    last_ms_ff  [CHANNEL_COUNT];
   logic [COUNTER_BITS-1:0] prev_ff     [CHANNEL_COUNT][LANES];
   logic [RATE_W-1:0]       rate_ff     [CHANNEL_COUNT][LANES];

   // Divider hookup
   logic                    div_start;
   logic                    div_done;
   logic [COUNTER_BITS-1:0] div_quotient;
   logic [COUNTER_BITS-1:0] delta;

   // Decode helpers
   logic                    is_sample;
   logic [TIME_BITS-1:0]    diff;
   logic                    time_ok;
   logic                    go_divide;
   logic                    use_unit;
   logic [63:0]             q64;
   logic [63:0]             limit;
   logic [63:0]             product;
   logic [RATE_W-1:0]       scaled;
   logic                    show_rates;

   // Elapsed time and decision to run the rate update
   always_comb begin
      is_sample = (cmd_ff == CMD_SAMPLE_RX) || (cmd_ff == CMD_SAMPLE_TX) ||
                  (cmd_ff == CMD_SAMPLE_USER);
      diff      = now_ff - last_ms_ff[ch_ff];
      time_ok   = (diff != '0) && !diff[TIME_BITS-1];
      go_divide = is_sample && baseline_ff[ch_ff] && time_ok;
      delta     = cnt_ff[lane_ff] - prev_ff[ch_ff][lane_ff];
   end

   // Scale the quotient by 8000 or 1000 with shift-subtract, saturating
   always_comb begin
      use_unit = (ch_ff != CH_USER) && (lane_ff == LANE_PACKETS);
      q64      = 64'(div_quotient);
      if (use_unit) begin
         limit   = UNIT_LIMIT;
         product = (q64 << 10) - (q64 << 4) - (q64 << 3);
      end else begin
         limit   = BIT_LIMIT;
         product = (q64 << 13) - (q64 << 7) - (q64 << 6);
      end
      scaled = (q64 > limit) ? RATE_MAX[RATE_W-1:0] : product[RATE_W-1:0];
   end

   assign show_rates = (status_ff == ST_UPDATED) || (status_ff == ST_BASELINE) ||
                       (status_ff == ST_STALE);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE:     if (req_valid) state_in = FSM_EXEC;
         FSM_EXEC:     state_in = go_divide ? FSM_DIV_LOAD : FSM_FINISH;
         FSM_DIV_LOAD: state_in = FSM_DIV_WAIT;
         FSM_DIV_WAIT: if (div_done) state_in = FSM_SCALE;
         FSM_SCALE:    state_in = (lane_ff == last_lane_ff) ? FSM_FINISH : FSM_DIV_LOAD;
         FSM_FINISH:   state_in = FSM_RESP;
         FSM_RESP:     if (!rsp_stall) state_in = FSM_IDLE;
         default:      state_in = FSM_IDLE;
      endcase
   end

   // Handshake and divider strobes
   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         FSM_IDLE:     req_stall = 1'b0;
         FSM_DIV_LOAD: div_start = 1'b1;
         FSM_RESP:     rsp_valid = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Capture, command execution, per-counter update and response build
   always_ff @(posedge clock) begin
      case (state_ff)
         FSM_IDLE: begin
            cmd_ff    <= req_data.command;
            now_ff    <= TIME_BITS'(req_data.now_ms);
            cnt_ff[0] <= COUNTER_BITS'(req_data.count_a);
            cnt_ff[1] <= COUNTER_BITS'(req_data.count_b);
            cnt_ff[2] <= COUNTER_BITS'(req_data.count_c);
            cnt_ff[3] <= COUNTER_BITS'(req_data.count_d);
            ch_ff     <= (req_data.command == CMD_CLEAR_ALL ||
                          req_data.command == CMD_CLEAR_RATES ||
                          req_data.command > CMD_CLEAR_RATES) ? '0 : req_data.command[CH_W-1:0];
            last_lane_ff <= (req_data.command == CMD_SAMPLE_USER) ? LAST_LANE_USR
                                                                  : LAST_LANE_NET;
         end
         FSM_EXEC: begin
            lane_ff    <= '0;
            elapsed_ff <= '0;
            if (cmd_ff == CMD_CLEAR_ALL || cmd_ff == CMD_CLEAR_RATES) begin
               status_ff <= ST_CLEARED;
            end else if (!is_sample) begin
               status_ff <= ST_INVALID;
            end else if (!baseline_ff[ch_ff]) begin
               status_ff <= ST_BASELINE;
            end else if (!time_ok) begin
               status_ff <= ST_STALE;
            end else begin
               status_ff  <= ST_UPDATED;
               elapsed_ff <= diff[TIME_BITS-2:0];
            end
         end
         FSM_SCALE: begin
            lane_ff <= lane_ff + LANE_W'(1);
         end
         FSM_FINISH: begin
            rsp_ff.status     <= status_ff;
            rsp_ff.elapsed_ms <= ELAPSED_W'(elapsed_ff);
            rsp_ff.rate_a     <= show_rates ? rate_ff[ch_ff][0] : '0;
            rsp_ff.rate_b     <= show_rates ? rate_ff[ch_ff][1] : '0;
            rsp_ff.rate_c     <= show_rates ? rate_ff[ch_ff][2] : '0;
            rsp_ff.rate_d     <= show_rates ? rate_ff[ch_ff][3] : '0;
         end
         default: begin
         end
      endcase
   end

   // Channel state updates
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNEL_COUNT; c++) begin
            baseline_ff[c] <= 1'b0;
            last_ms_ff[c]  <= '0;
            for (int k = 0; k < LANES; k++) begin
               prev_ff[c][k] <= '0;
               rate_ff[c][k] <= '0;
            end
         end
      end else begin
         case (state_ff)
            FSM_EXEC: begin
               if (cmd_ff == CMD_CLEAR_ALL) begin
                  for (int c = 0; c < CHANNEL_COUNT; c++) begin
                     baseline_ff[c] <= 1'b0;
                     last_ms_ff[c]  <= '0;
                     for (int k = 0; k < LANES; k++) begin
                        prev_ff[c][k] <= '0;
                        rate_ff[c][k] <= '0;
                     end
                  end
               end else if (cmd_ff == CMD_CLEAR_RATES) begin
                  for (int c = 0; c < CHANNEL_COUNT; c++) begin
                     for (int k = 0; k < LANES; k++) begin
                        rate_ff[c][k] <= '0;
                     end
                  end
               end else if (is_sample && !baseline_ff[ch_ff]) begin
                  // First sample: record the baseline only
                  baseline_ff[ch_ff] <= 1'b1;
                  last_ms_ff[ch_ff]  <= now_ff;
                  for (int k = 0; k < LANES; k++) begin
                     if (LANE_W'(k) <= last_lane_ff) begin
                        prev_ff[ch_ff][k] <= cnt_ff[k];
                     end
                  end
               end
            end
            FSM_SCALE: begin
               rate_ff[ch_ff][lane_ff] <= scaled;
               prev_ff[ch_ff][lane_ff] <= cnt_ff[lane_ff];
               if (lane_ff == last_lane_ff) begin
                  last_ms_ff[ch_ff] <= now_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Shared serial divider: counter delta over elapsed ms
   trm_divider #(
      .DIVIDEND_BITS (COUNTER_BITS),
      .DIVISOR_BITS  (TIME_BITS - 1)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (delta),
      .divisor  (elapsed_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_data = rsp_ff;

endmodule

// ===== tb/traffic_rate_meter_tb.sv =====
// Self-checking testbench for the traffic rate meter: directed, back-pressure and random tests.
module traffic_rate_meter_tb;
   import trm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Codes above the clear-rates command are rejected by the block
   localparam logic [CMD_W-1:0] CMD_BAD_LO  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_BAD_MID = 3'd6;
   localparam logic [CMD_W-1:0] CMD_BAD_HI  = 3'd7;

   localparam logic [COUNT_W-1:0] CNT_MAX     = {COUNT_W{1'b1}};
   localparam logic [63:0]        RATE_CEIL   = (64'd1 << RATE_W) - 64'd1;
   localparam logic [63:0]        BIT_SCALE   = 64'd8000;
   localparam logic [63:0]        UNIT_SCALE  = 64'd1000;
   localparam int                 CYCLE_LIMIT = 1000000;
   localparam int                 DRAIN_WAIT  = 250;
   localparam int                 HOLD_CYCLES = 1000;
   localparam int                 RANDOM_ITEMS = 400;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   traffic_rate_meter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predicted meter state
   logic                ch_primed [CHANNEL_COUNT];
   logic [NOW_W-1:0]    ch_last_ms [CHANNEL_COUNT];
   logic [COUNT_W-1:0]  ch_totals [CHANNEL_COUNT][LANES];
   logic [RATE_W-1:0]   ch_rates [CHANNEL_COUNT][LANES];

   rsp_type predicted_readings [$];
   int      mismatch_count = 0;
   int      cycle_count = 0;

   // Idle control shared between the test tasks and the receive process
   bit gaps_on = 1'b0;
   bit stalls_on = 1'b0;
   int hold_request = 0;
   int stall_left = 0;

   // Stimulus-side image of what each channel has been sent
   logic [NOW_W-1:0]   src_ms [CHANNEL_COUNT];
   logic [COUNT_W-1:0] src_totals [CHANNEL_COUNT][LANES];

   function automatic void clear_rates();
      foreach (ch_rates[c, k]) ch_rates[c][k] = '0;
   endfunction

   // Expected reading for one accepted command; updates the predicted state
   function automatic rsp_type predict_reading(input req_type item);
      rsp_type            r;
      logic [NOW_W-1:0]   span;
      logic [COUNT_W-1:0] cur [LANES];
      logic [COUNT_W-1:0] delta;
      logic [63:0]        quot;
      logic [63:0]        scale;
      int                 ch;
      int                 lanes;
      r = '0;
      cur[0] = item.count_a;
      cur[1] = item.count_b;
      cur[2] = item.count_c;
      cur[3] = item.count_d;
      case (item.command)
         CMD_CLEAR_ALL: begin
            foreach (ch_primed[c]) begin
               ch_primed[c] = 1'b0;
               ch_last_ms[c] = '0;
            end
            foreach (ch_totals[c, k]) ch_totals[c][k] = '0;
            clear_rates();
            r.status = ST_CLEARED;
         end
         CMD_CLEAR_RATES: begin
            clear_rates();
            r.status = ST_CLEARED;
         end
         CMD_SAMPLE_RX, CMD_SAMPLE_TX, CMD_SAMPLE_USER: begin
            ch = int'(item.command);
            lanes = (item.command == CMD_SAMPLE_USER) ? 4 : 3;
            if (!ch_primed[ch]) begin
               // first sample only records the baseline
               ch_primed[ch] = 1'b1;
               ch_last_ms[ch] = item.now_ms;
               for (int k = 0; k < lanes; k++) ch_totals[ch][k] = cur[k];
               r.status = ST_BASELINE;
            end else begin
               span = item.now_ms - ch_last_ms[ch];
               if (span == '0 || span[NOW_W-1]) begin
                  r.status = ST_STALE;
               end else begin
                  for (int k = 0; k < lanes; k++) begin
                     delta = cur[k] - ch_totals[ch][k];
                     scale = (ch != int'(CH_USER) && k == int'(LANE_PACKETS)) ?
                             UNIT_SCALE : BIT_SCALE;
                     quot = 64'(delta) / 64'(span);
                     if (quot > RATE_CEIL / scale) ch_rates[ch][k] = RATE_CEIL[RATE_W-1:0];
                     else ch_rates[ch][k] = RATE_W'(quot * scale);
                     ch_totals[ch][k] = cur[k];
                  end
                  ch_last_ms[ch] = item.now_ms;
                  r.status = ST_UPDATED;
                  r.elapsed_ms = span[ELAPSED_W-1:0];
               end
            end
            r.rate_a = ch_rates[ch][0];
            r.rate_b = ch_rates[ch][1];
            r.rate_c = ch_rates[ch][2];
            r.rate_d = ch_rates[ch][3];
         end
         default: r.status = ST_INVALID;
      endcase
      return r;
   endfunction

   // Mostly short idle runs, now and then a long one
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   function automatic logic [COUNT_W-1:0] random_count();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[COUNT_W-1:0];
   endfunction

   function automatic req_type make_req(input logic [CMD_W-1:0] cmd,
                                        input logic [NOW_W-1:0] now,
                                        input logic [COUNT_W-1:0] a, b, c, d);
      req_type item;
      item.command = cmd;
      item.now_ms = now;
      item.count_a = a;
      item.count_b = b;
      item.count_c = c;
      item.count_d = d;
      return item;
   endfunction

   // Offer one command, hold it until taken, then log its expected reading
   task automatic send_request(input req_type item);
      int gap;
      gap = (gaps_on && $urandom_range(0, 1) == 1) ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted_readings.push_back(predict_reading(item));
   endtask

   task automatic wait_drained();
      while (predicted_readings.size() != 0) @(posedge clock);
   endtask

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Response side: compare each transaction taken, then pick the next stall
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_readings.size() == 0) begin
               $display("%0t: unexpected reading, expected none, actual %h", $time, rsp_data);
               mismatch_count++;
            end else begin
               want = predicted_readings.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_data.status));
               check_field("elapsed_ms", 64'(want.elapsed_ms), 64'(rsp_data.elapsed_ms));
               check_field("rate_a", 64'(want.rate_a), 64'(rsp_data.rate_a));
               check_field("rate_b", 64'(want.rate_b), 64'(rsp_data.rate_b));
               check_field("rate_c", 64'(want.rate_c), 64'(rsp_data.rate_c));
               check_field("rate_d", 64'(want.rate_d), 64'(rsp_data.rate_d));
            end
         end
         if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
         end else if (stall_left == 0 && stalls_on && $urandom_range(0, 2) == 0) begin
            stall_left = idle_length();
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("traffic_rate_meter regression: fail");
         $finish;
      end
   end

   // Field extremes, every command, baseline, stale and negative time, wrap and clears
   task automatic test_directed();
      logic [COUNT_W-1:0] r1, r2, r3;
      r1 = random_count();
      r2 = random_count();
      r3 = random_count();
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      send_request(make_req(CMD_BAD_HI, '1, CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX));
      send_request(make_req(CMD_SAMPLE_RX, 32'hFFFF_FFF0, CNT_MAX, CNT_MAX, CNT_MAX, 48'h123));
      send_request(make_req(CMD_SAMPLE_RX, 32'hFFFF_FFF0, 48'd1, 48'd2, 48'd3, 48'd4));
      // half a time wrap ahead reads as negative
      send_request(make_req(CMD_SAMPLE_RX, 32'h7FFF_FFF0, 48'd1, 48'd2, 48'd3, 48'd4));
      // time and counters wrap through zero
      send_request(make_req(CMD_SAMPLE_RX, 32'h0, 48'd0, 48'd159999, CNT_MAX, CNT_MAX));
      send_request(make_req(CMD_SAMPLE_RX, 32'h1, CNT_MAX, 48'd159999, 48'd5000, 48'd0));
      gaps_on = 1'b1;
      stalls_on = 1'b1;
      send_request(make_req(CMD_SAMPLE_TX, 32'h0, 48'd0, 48'd0, 48'd0, CNT_MAX));
      send_request(make_req(CMD_SAMPLE_TX, 32'h7FFF_FFFF, CNT_MAX, r1, r2, r3));
      send_request(make_req(CMD_SAMPLE_TX, 32'h8000_0000, CNT_MAX, r1, r2, r3));
      send_request(make_req(CMD_SAMPLE_USER, 32'd100, 48'd0, 48'd0, 48'd0, 48'd0));
      send_request(make_req(CMD_SAMPLE_USER, 32'd101, CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX));
      send_request(make_req(CMD_SAMPLE_USER, 32'd101, r3, r2, r1, r3));
      send_request(make_req(CMD_CLEAR_RATES, $urandom, r1, r2, r3, r1));
      send_request(make_req(CMD_SAMPLE_RX, 32'd3, 48'd1000, 48'd160999, 48'd5001, r2));
      send_request(make_req(CMD_BAD_LO, $urandom, r1, r2, r3, r1));
      send_request(make_req(CMD_BAD_MID, 32'h0, 48'd0, 48'd0, 48'd0, 48'd0));
      send_request(make_req(CMD_CLEAR_ALL, $urandom, r3, r2, r1, r2));
      send_request(make_req(CMD_SAMPLE_USER, 32'd500, r1, r2, r3, r1));
      send_request(make_req(CMD_SAMPLE_RX, 32'd0, r1, r2, r3, r1));
      send_request(make_req(CMD_SAMPLE_TX, 32'd0, 48'd7, 48'd8, 48'd9, 48'd10));
      send_request(make_req(CMD_SAMPLE_USER, 32'd400, r2, r2, r2, r2));
      send_request(make_req(CMD_SAMPLE_USER, 32'd1500, random_count(), random_count(),
                            random_count(), random_count()));
      req_valid <= 1'b0;
      wait_drained();
   endtask

   // Receiver holds off while the sender keeps offering commands back to back
   task automatic test_backpressure();
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      hold_request = HOLD_CYCLES;
      for (int i = 0; i < 8; i++)
         send_request(make_req(CMD_SAMPLE_TX, 32'd10 * i + 32'd5, random_count(),
                               random_count(), random_count(), random_count()));
      req_valid <= 1'b0;
      wait_drained();
   endtask

   // Mostly well-formed sample streams per channel, with some stale time, clears and noise
   task automatic test_random();
      req_type            item;
      logic [COUNT_W-1:0] step;
      logic [NOW_W-1:0]   adv;
      int                 pick;
      int                 ch;
      foreach (src_ms[c]) src_ms[c] = $urandom;
      foreach (src_totals[c, k]) src_totals[c][k] = random_count();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // idle pattern changes every few dozen transactions
         if (n % 40 == 0) begin
            gaps_on = $urandom_range(0, 2) != 0;
            stalls_on = $urandom_range(0, 2) != 0;
         end
         pick = $urandom_range(0, 99);
         if (pick < 82) begin
            ch = $urandom_range(0, CHANNEL_COUNT - 1);
            pick = $urandom_range(0, 99);
            if (pick < 80) adv = $urandom_range(1, 1000);
            else if (pick < 87) adv = '0;
            else if (pick < 94) adv = $urandom_range(1001, 32'h7FFF_FFFF);
            else adv = $urandom_range(32'h8000_0000, 32'hFFFF_FFFF);
            src_ms[ch] = src_ms[ch] + adv;
            for (int k = 0; k < LANES; k++) begin
               pick = $urandom_range(0, 9);
               if (pick < 6) step = COUNT_W'($urandom_range(0, 2000000));
               else if (pick < 9) step = COUNT_W'($urandom);
               else step = random_count();
               src_totals[ch][k] = src_totals[ch][k] + step;
            end
            item = make_req(CMD_W'(ch), src_ms[ch], src_totals[ch][0], src_totals[ch][1],
                            src_totals[ch][2], src_totals[ch][3]);
         end else if (pick < 85) begin
            item = make_req(CMD_CLEAR_ALL, $urandom, random_count(), random_count(),
                            random_count(), random_count());
         end else if (pick < 89) begin
            item = make_req(CMD_CLEAR_RATES, $urandom, random_count(), random_count(),
                            random_count(), random_count());
         end else begin
            item = make_req(CMD_W'($urandom_range(0, 7)), $urandom, random_count(),
                            random_count(), random_count(), random_count());
         end
         send_request(item);
      end
      req_valid <= 1'b0;
      stalls_on = 1'b0;
      wait_drained();
   endtask

   initial begin
      // predicted state starts out as the block does after reset
      foreach (ch_primed[c]) begin
         ch_primed[c] = 1'b0;
         ch_last_ms[c] = '0;
      end
      foreach (ch_totals[c, k]) ch_totals[c][k] = '0;
      clear_rates();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0 && predicted_readings.size() == 0)
         $display("traffic_rate_meter regression: pass");
      else
         $display("traffic_rate_meter regression: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/trm_pkg.sv
hdl/trm_divider.sv
hdl/traffic_rate_meter.sv
tb/traffic_rate_meter_tb.sv
